// File: rtl/keyboard_command_snoop_parser_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef KEYBOARD_COMMAND_SNOOP_PARSER_MACROS_SVH
`define KEYBOARD_COMMAND_SNOOP_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define KCSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define KCSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KCSP_ASSERT_IMP(lbl, ante, cons, msg)

`define KCSP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/kcsp_pkg.sv
package kcsp_pkg;

  localparam logic [7:0] OP_RESET          = 8'h80;
  localparam logic [7:0] RESET_ARG         = 8'h01;
  localparam logic [7:0] OP_MEM_LOAD       = 8'h20;
  localparam logic [7:0] OP_PTR_REL        = 8'h08;
  localparam logic [7:0] OP_PTR_ABS        = 8'h09;
  localparam logic [7:0] OP_PTR_KEY        = 8'h0A;
  localparam logic [7:0] OP_PTR_OFF        = 8'h12;
  localparam logic [7:0] OP_Y_UP           = 8'h0F;
  localparam logic [7:0] OP_Y_DOWN         = 8'h10;
  localparam logic [7:0] OP_RESUME         = 8'h11;
  localparam logic [7:0] OP_PAUSE          = 8'h13;
  localparam logic [7:0] OP_JOY_EVENTS     = 8'h14;
  localparam logic [7:0] OP_JOY_INTERRO    = 8'h15;
  localparam logic [7:0] OP_JOY_OFF        = 8'h1A;
  localparam logic [7:0] OP_BUTTON_ACTION  = 8'h07;
  localparam logic [7:0] OP_MOUSE_THRESH   = 8'h0B;
  localparam logic [7:0] OP_MOUSE_SCALE    = 8'h0C;
  localparam logic [7:0] OP_LOAD_MOUSE_POS = 8'h0E;
  localparam logic [7:0] OP_JOY_MONITOR    = 8'h17;
  localparam logic [7:0] OP_JOY_KEYCODE    = 8'h19;
  localparam logic [7:0] OP_CLOCK_SET      = 8'h1B;
  localparam logic [7:0] OP_MEM_READ       = 8'h21;
  localparam logic [7:0] OP_EXECUTE        = 8'h22;

  localparam logic [1:0] CTRL_MASTER_RESET = 2'b11;

  localparam logic [1:0] PTR_REL = 2'd0;
  localparam logic [1:0] PTR_ABS = 2'd1;
  localparam logic [1:0] PTR_KEY = 2'd2;
  localparam logic [1:0] PTR_OFF = 2'd3;

  localparam logic [1:0] ROLE_OPCODE  = 2'd0;
  localparam logic [1:0] ROLE_PARAM   = 2'd1;
  localparam logic [1:0] ROLE_LOAD    = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0] byte_role;
    logic       flush_request;
    logic       joystick_events;
    logic       paused;
    logic       y_down;
    logic [1:0] ptr_mode;
  } result_t;

  function automatic logic [2:0] param_count(logic [7:0] op);
    logic [2:0] n;
    case (op)
      OP_RESET, OP_BUTTON_ACTION, OP_JOY_MONITOR: n = 3'd1;
      OP_PTR_KEY, OP_MOUSE_THRESH, OP_MOUSE_SCALE,
      OP_MEM_READ, OP_EXECUTE:                    n = 3'd2;
      OP_MEM_LOAD:                                n = 3'd3;
      OP_PTR_ABS:                                 n = 3'd4;
      OP_LOAD_MOUSE_POS:                          n = 3'd5;
      OP_JOY_KEYCODE, OP_CLOCK_SET:               n = 3'd6;
      default:                                    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/keyboard_command_snoop_parser.sv
// Channel      | Direction | Contents
// s_axis       | in        | tdata: write_byte[7:0]; tuser: mode[0]
// m_axis       | out       | tdata: ptr_mode, y_down, paused, joystick_events,
//              |           |        flush_request; tuser: byte_role[1:0]
// cfg          | in        | data: enable[0]
//
// One byte per cycle while s_axis is not stalled: each byte is decoded and the mode
// registers updated in the cycle it is accepted, and its result is registered.
// A two-entry output stage (result register plus skid) keeps s_axis open while one
// result waits; s_axis stalls only when both entries are full.
// Reset puts all modes at their defaults and leaves the parser disabled.
module keyboard_command_snoop_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_data_i,     // enable
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // write_byte[7:0]
  input  logic [0:0] s_axis_tuser,   // mode[0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // ptr_mode[1:0], y_down[2], paused[3],
                                     // joystick_events[4], flush_request[5], zero[7:6]
  output logic [1:0] m_axis_tuser    // byte_role[1:0]
);
  import kcsp_pkg::*;

  logic       enable_q;
  logic [1:0] mouse_q, mouse_d;
  logic       ydown_q, ydown_d;
  logic       paused_q, paused_d;
  logic       joy_q, joy_d;
  logic [7:0] pending_q, pending_d;
  logic [2:0] params_q, params_d;
  logic [7:0] load_q, load_d;

  result_t    res_d;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       accept;
  logic [2:0] n_params;
  logic [2:0] params_dec;
  logic       flush;
  logic [1:0] role;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign n_params   = param_count(s_axis_tdata);
  assign params_dec = params_q - 3'd1;

  always_comb begin
    mouse_d   = mouse_q;
    ydown_d   = ydown_q;
    paused_d  = paused_q;
    joy_d     = joy_q;
    pending_d = pending_q;
    params_d  = params_q;
    load_d    = load_q;
    flush     = 1'b0;
    role      = ROLE_IGNORED;
    if (enable_q) begin
      if (s_axis_tuser[0]) begin
        flush = (s_axis_tdata[1:0] == CTRL_MASTER_RESET);
      end else if (load_q != 8'd0) begin
        load_d = load_q - 8'd1;
        role   = ROLE_LOAD;
      end else if (params_q != 3'd0) begin
        role     = ROLE_PARAM;
        params_d = params_dec;
        if (pending_q == OP_RESET && s_axis_tdata == RESET_ARG) begin
          mouse_d  = PTR_REL;
          ydown_d  = 1'b1;
          paused_d = 1'b0;
          joy_d    = 1'b1;
          params_d = 3'd0;
          load_d   = 8'd0;
          flush    = 1'b1;
        end else if (pending_q == OP_MEM_LOAD && params_dec == 3'd0) begin
          load_d = s_axis_tdata;
        end
        if (params_d == 3'd0) begin
          pending_d = 8'd0;
        end
      end else begin
        role = ROLE_OPCODE;
        if (n_params != 3'd0) begin
          pending_d = s_axis_tdata;
          params_d  = n_params;
        end
        case (s_axis_tdata)
          OP_PTR_REL:                 mouse_d  = PTR_REL;
          OP_PTR_ABS:                 mouse_d  = PTR_ABS;
          OP_PTR_KEY:                 mouse_d  = PTR_KEY;
          OP_PTR_OFF:                 mouse_d  = PTR_OFF;
          OP_Y_UP:                    ydown_d  = 1'b0;
          OP_Y_DOWN:                  ydown_d  = 1'b1;
          OP_RESUME:                  paused_d = 1'b0;
          OP_PAUSE:                   paused_d = 1'b1;
          OP_JOY_EVENTS:              joy_d    = 1'b1;
          OP_JOY_INTERRO, OP_JOY_OFF: joy_d    = 1'b0;
          default: ;
        endcase
      end
    end
    res_d.ptr_mode        = mouse_d;
    res_d.y_down          = ydown_d;
    res_d.paused          = paused_d;
    res_d.joystick_events = joy_d;
    res_d.flush_request   = flush;
    res_d.byte_role       = role;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      mouse_q   <= PTR_REL;
      ydown_q   <= 1'b1;
      paused_q  <= 1'b0;
      joy_q     <= 1'b1;
      pending_q <= 8'd0;
      params_q  <= 3'd0;
      load_q    <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        enable_q <= cfg_data_i[0];
      end
      if (accept) begin
        mouse_q   <= mouse_d;
        ydown_q   <= ydown_d;
        paused_q  <= paused_d;
        joy_q     <= joy_d;
        pending_q <= pending_d;
        params_q  <= params_d;
        load_q    <= load_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || m_axis_tready) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.flush_request, out_q.joystick_events,
                          out_q.paused, out_q.y_down, out_q.ptr_mode};
  assign m_axis_tuser  = out_q.byte_role;

`include "keyboard_command_snoop_parser_macros.svh"

  `KCSP_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full, output empty")
  `KCSP_ASSERT_NXT(a_stall_fills_skid, out_valid_q && !m_axis_tready && accept,
                   skid_valid_q, "stalled transaction lost")
  `KCSP_ASSERT_IMP(a_load_excludes_params, load_q != 8'd0, params_q == 3'd0,
                   "load and params both active")
  `KCSP_ASSERT_IMP(a_params_have_opcode, params_q != 3'd0,
                   pending_q != 8'd0 && params_q <= 3'd6, "params without opcode")

endmodule

// File: dv/tb_keyboard_command_snoop_parser.sv
`timescale 1ns / 1ps

module tb_keyboard_command_snoop_parser;
  import kcsp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTS     = 30;

  localparam logic WR_DATA = 1'b0;
  localparam logic WR_CTRL = 1'b1;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [0:0] cfg_data_i    = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic [0:0] s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  keyboard_command_snoop_parser i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow parser state
  logic       parse_en;
  logic [1:0] mouse_q;
  logic       ydown_q;
  logic       paused_q;
  logic       joy_q;
  logic [7:0] cur_op;
  logic [2:0] args_left;
  logic [7:0] load_left;

  result_t mode_results[$];

  int  mismatches;
  int  results_seen;
  int  active_bytes;
  int  ignored_bytes;
  int  flush_count;
  int  load_bytes;
  int  input_stalls;
  int  idle_cycles;
  bit  tx_no_gaps;
  int  rx_hold;
  int  rx_stall;
  int  rx_free;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [2:0] cmd_arg_count(logic [7:0] op);
    case (op)
      OP_RESET, OP_BUTTON_ACTION, OP_JOY_MONITOR: return 3'd1;
      OP_PTR_KEY, OP_MOUSE_THRESH, OP_MOUSE_SCALE,
      OP_MEM_READ, OP_EXECUTE:                    return 3'd2;
      OP_MEM_LOAD:                                return 3'd3;
      OP_PTR_ABS:                                 return 3'd4;
      OP_LOAD_MOUSE_POS:                          return 3'd5;
      OP_JOY_KEYCODE, OP_CLOCK_SET:               return 3'd6;
      default:                                    return 3'd0;
    endcase
  endfunction

  function automatic void restore_defaults();
    mouse_q   = PTR_REL;
    ydown_q   = 1'b1;
    paused_q  = 1'b0;
    joy_q     = 1'b1;
    cur_op    = 8'h00;
    args_left = 3'd0;
    load_left = 8'h00;
  endfunction

  function automatic result_t parse_byte(logic ctrl, logic [7:0] b);
    result_t    r;
    logic [2:0] n;
    r = '0;
    r.byte_role = ROLE_IGNORED;
    if (parse_en) begin
      if (ctrl) begin
        r.flush_request = (b[1:0] == CTRL_MASTER_RESET);
      end else if (load_left != 8'h00) begin
        load_left   = load_left - 8'd1;
        r.byte_role = ROLE_LOAD;
      end else if (args_left != 3'd0) begin
        r.byte_role = ROLE_PARAM;
        args_left   = args_left - 3'd1;
        if (cur_op == OP_RESET && b == RESET_ARG) begin
          restore_defaults();
          r.flush_request = 1'b1;
        end else if (cur_op == OP_MEM_LOAD && args_left == 3'd0) begin
          load_left = b;
        end
        if (args_left == 3'd0) cur_op = 8'h00;
      end else begin
        r.byte_role = ROLE_OPCODE;
        n = cmd_arg_count(b);
        if (n != 3'd0) begin
          cur_op    = b;
          args_left = n;
        end
        case (b)
          OP_PTR_REL:                   mouse_q  = PTR_REL;
          OP_PTR_ABS:                   mouse_q  = PTR_ABS;
          OP_PTR_KEY:                   mouse_q  = PTR_KEY;
          OP_PTR_OFF:                   mouse_q  = PTR_OFF;
          OP_Y_UP:                      ydown_q  = 1'b0;
          OP_Y_DOWN:                    ydown_q  = 1'b1;
          OP_RESUME:                    paused_q = 1'b0;
          OP_PAUSE:                     paused_q = 1'b1;
          OP_JOY_EVENTS:                joy_q    = 1'b1;
          OP_JOY_INTERRO, OP_JOY_OFF:   joy_q    = 1'b0;
          default: ;
        endcase
      end
    end
    r.ptr_mode        = mouse_q;
    r.y_down          = ydown_q;
    r.paused          = paused_q;
    r.joystick_events = joy_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] MISMATCH result %0d %s: got %0d, want %0d",
               $time, results_seen, what, got, want);
  endtask

  // Send one snooped write; returns just after the accepting edge.
  task automatic send_byte(logic ctrl, logic [7:0] b);
    int      gap;
    result_t r;
    gap = tx_no_gaps ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= ctrl;
    do @(posedge clk_i); while (!s_axis_tready);
    r = parse_byte(ctrl, b);
    mode_results.push_back(r);
    if (r.byte_role == ROLE_IGNORED) ignored_bytes++;
    else active_bytes++;
    if (r.byte_role == ROLE_LOAD) load_bytes++;
    if (r.flush_request) flush_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mode_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enable(logic en);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    parse_en = en;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 21))
      0:  return OP_RESET;
      1:  return OP_MEM_LOAD;
      2:  return OP_PTR_REL;
      3:  return OP_PTR_ABS;
      4:  return OP_PTR_KEY;
      5:  return OP_PTR_OFF;
      6:  return OP_Y_UP;
      7:  return OP_Y_DOWN;
      8:  return OP_RESUME;
      9:  return OP_PAUSE;
      10: return OP_JOY_EVENTS;
      11: return OP_JOY_INTERRO;
      12: return OP_JOY_OFF;
      13: return OP_BUTTON_ACTION;
      14: return OP_MOUSE_THRESH;
      15: return OP_MOUSE_SCALE;
      16: return OP_LOAD_MOUSE_POS;
      17: return OP_JOY_MONITOR;
      18: return OP_JOY_KEYCODE;
      19: return OP_CLOCK_SET;
      20: return OP_MEM_READ;
      default: return OP_EXECUTE;
    endcase
  endfunction

  // One command: mostly well formed, some noise and interleaved control writes.
  task automatic send_random_command();
    int         r;
    int         n;
    logic [7:0] op;
    logic [7:0] p;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_byte(WR_CTRL, 8'($urandom_range(0, 255)));
    end else if (r < 14) begin
      send_byte(WR_DATA, 8'($urandom_range(0, 255)));
    end else if (r < 20) begin
      send_byte(WR_DATA, OP_RESET);
      send_byte(WR_DATA, ($urandom_range(0, 2) != 0) ? RESET_ARG : 8'($urandom_range(0, 255)));
    end else begin
      op = pick_opcode();
      send_byte(WR_DATA, op);
      n = int'(cmd_arg_count(op));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) send_byte(WR_CTRL, 8'($urandom_range(0, 255)));
        p = 8'($urandom_range(0, 255));
        if (op == OP_MEM_LOAD && i == 2)
          p = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 6));
        send_byte(WR_DATA, p);
        if (op == OP_MEM_LOAD && i == 2)
          for (int k = 0; k < int'(p); k++) send_byte(WR_DATA, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_reset_state();
    send_byte(WR_CTRL, 8'hFF);
    send_byte(WR_DATA, OP_PAUSE);
    send_byte(WR_DATA, OP_PTR_OFF);
    write_enable(1'b1);
  endtask

  task automatic test_control_writes();
    send_byte(WR_CTRL, 8'h03);
    send_byte(WR_CTRL, 8'hFC);
    send_byte(WR_CTRL, 8'hFF);
  endtask

  task automatic test_mode_opcodes();
    send_byte(WR_DATA, OP_PTR_OFF);
    send_byte(WR_DATA, OP_Y_UP);
    send_byte(WR_DATA, OP_PAUSE);
    send_byte(WR_DATA, OP_JOY_OFF);
    send_byte(WR_DATA, OP_PTR_ABS);
    send_byte(WR_DATA, 8'h00);
    send_byte(WR_DATA, 8'hFF);
    send_byte(WR_DATA, OP_RESET);
    send_byte(WR_DATA, RESET_ARG);
    send_byte(WR_DATA, OP_PTR_KEY);
    send_byte(WR_DATA, 8'h55);
    send_byte(WR_DATA, 8'hAA);
    send_byte(WR_DATA, OP_PTR_REL);
    send_byte(WR_DATA, OP_Y_DOWN);
    send_byte(WR_DATA, OP_RESUME);
    send_byte(WR_DATA, OP_JOY_INTERRO);
    send_byte(WR_DATA, OP_JOY_EVENTS);
    send_byte(WR_DATA, 8'hFF);
  endtask

  task automatic test_reset_sequence();
    send_byte(WR_DATA, OP_PTR_OFF);
    send_byte(WR_DATA, OP_RESET);
    send_byte(WR_DATA, 8'h02);
    send_byte(WR_DATA, OP_RESET);
    send_byte(WR_DATA, RESET_ARG);
  endtask

  task automatic test_memory_load();
    send_byte(WR_DATA, OP_MEM_LOAD);
    send_byte(WR_DATA, 8'h12);
    send_byte(WR_DATA, 8'h34);
    send_byte(WR_DATA, 8'h00);
    send_byte(WR_DATA, OP_PAUSE);
    send_byte(WR_DATA, OP_MEM_LOAD);
    send_byte(WR_DATA, 8'h00);
    send_byte(WR_DATA, 8'h80);
    send_byte(WR_DATA, 8'h02);
    send_byte(WR_DATA, OP_RESET);
    send_byte(WR_DATA, OP_RESET);
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    rx_hold    = 64;
    tx_no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) send_random_command();
    tx_no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_commands(int n_items);
    int target;
    target = active_bytes + n_items;
    while (active_bytes < target) begin
      if ($urandom_range(0, 39) == 0) tx_no_gaps = !tx_no_gaps;
      if ($urandom_range(0, 99) == 0) wait_drained();
      send_random_command();
    end
    tx_no_gaps = 1'b0;
  endtask

  task automatic test_disabled_holds();
    write_enable(1'b0);
    for (int i = 0; i < 40; i++) send_random_command();
    write_enable(1'b1);
  endtask

  // result receiver with random stalls, free-running stretches and forced hold-off
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_free > 0) rx_free = rx_free - 1;
      else if ($urandom_range(0, 3) == 0) rx_stall = pick_gap();
      else if ($urandom_range(0, 15) == 0) rx_free = $urandom_range(20, 80);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (mode_results.size() == 0) begin
        report_mismatch("unexpected transaction, tdata", int'(m_axis_tdata), 0);
      end else begin
        want = mode_results.pop_front();
        if (m_axis_tdata[1:0] != want.ptr_mode)
          report_mismatch("ptr_mode", int'(m_axis_tdata[1:0]), int'(want.ptr_mode));
        if (m_axis_tdata[2] != want.y_down)
          report_mismatch("y_down", int'(m_axis_tdata[2]), int'(want.y_down));
        if (m_axis_tdata[3] != want.paused)
          report_mismatch("paused", int'(m_axis_tdata[3]), int'(want.paused));
        if (m_axis_tdata[4] != want.joystick_events)
          report_mismatch("joystick_events", int'(m_axis_tdata[4]), int'(want.joystick_events));
        if (m_axis_tdata[5] != want.flush_request)
          report_mismatch("flush_request", int'(m_axis_tdata[5]), int'(want.flush_request));
        if (m_axis_tdata[7:6] != 2'b00)
          report_mismatch("tdata pad bits", int'(m_axis_tdata[7:6]), 0);
        if (m_axis_tuser != want.byte_role)
          report_mismatch("byte_role", int'(m_axis_tuser), int'(want.byte_role));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, mode_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    parse_en = 1'b0;
    restore_defaults();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_control_writes();
    test_mode_opcodes();
    test_reset_sequence();
    test_memory_load();
    test_output_backpressure();
    test_random_commands(1100);
    test_disabled_holds();
    test_random_commands(500);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d parsed bytes and %0d ignored writes, %0d results checked,",
             active_bytes, ignored_bytes, results_seen);
    $display("%0d flush requests, %0d memory-load bytes, %0d input stall cycles",
             flush_count, load_bytes, input_stalls);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
